// ----- rtl/hsmtf_pkg.sv -----
// Shared constants, types and helper functions of the half scale mirror tile framer.
package hsmtf_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAME_MIN  = 4;
    localparam int FRAME_MAX  = 20;

    localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
    localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
    localparam int STORE_DEPTH = HALF_W * HALF_H;
    localparam int ADDR_W     = $clog2(STORE_DEPTH);
    localparam int HROW_W     = $clog2(HALF_H);
    localparam int HCOL_W     = $clog2(HALF_W);

    localparam int LROW_W     = $clog2(MAX_HEIGHT);
    localparam int LCOL_W     = $clog2(MAX_WIDTH);

    localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int POS_W      = $clog2(MAX_DIM + 3 * FRAME_MAX);
    localparam int SUM_W      = POS_W + 1;

    localparam int DIM_REG_W  = 9;
    localparam int FRAME_REG_W = 5;
    localparam int COLOR_W    = 8;
    localparam int PIXEL_W    = 3 * COLOR_W;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_SIZE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_RED     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_GREEN   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BLUE    = 3'd5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    typedef struct packed {
        logic [DIM_REG_W-1:0]   source_width;
        logic [DIM_REG_W-1:0]   source_height;
        logic [FRAME_REG_W-1:0] frame_size;
    } geom_t;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic              use_store;
        logic              row_end;
        logic              image_end;
    } ctrl_t;

    function automatic logic [SUM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v,
                                                   input int max_v);
        logic [SUM_W-1:0] r;
        r = SUM_W'(v);
        if (v == '0) begin
            r = SUM_W'(1);
        end else if (r > SUM_W'(max_v)) begin
            r = SUM_W'(max_v);
        end
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] clamp_frame(input logic [FRAME_REG_W-1:0] v);
        logic [SUM_W-1:0] r;
        r = SUM_W'(v);
        if (r < SUM_W'(FRAME_MIN)) begin
            r = SUM_W'(FRAME_MIN);
        end else if (r > SUM_W'(FRAME_MAX)) begin
            r = SUM_W'(FRAME_MAX);
        end
        return r;
    endfunction

endpackage

// ----- rtl/hsmtf_ram.sv -----
// Generic simple dual port RAM with a registered read port.
module hsmtf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/hsmtf_ctrl.sv -----
// Load and fetch position counters with the store address and tile mapping.
module hsmtf_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic                  operation,
    input  hsmtf_pkg::geom_t      geom,
    output hsmtf_pkg::ctrl_t      ctrl
);

    localparam int SW = hsmtf_pkg::SUM_W;

    logic [hsmtf_pkg::LROW_W-1:0] load_row_reg, load_row_next;
    logic [hsmtf_pkg::LCOL_W-1:0] load_col_reg, load_col_next;
    logic [hsmtf_pkg::POS_W-1:0]  emit_row_reg, emit_row_next;
    logic [hsmtf_pkg::POS_W-1:0]  emit_col_reg, emit_col_next;

    logic [SW-1:0] w_e, h_e, n_e, hw_e, hh_e, ow, oh, up, rs, rend;
    logic [SW-1:0] r_e, c_e, lr_e, lc_e, i_e, j_e;
    logic          row_ok, col_ok, load_ok, row_end, image_end;
    logic [hsmtf_pkg::HROW_W-1:0] ld_i, em_i;
    logic [hsmtf_pkg::HCOL_W-1:0] ld_j, em_j;
    logic [hsmtf_pkg::ADDR_W-1:0] ld_addr, em_addr;
    logic          do_load, do_fetch;

    always_comb begin
        w_e  = hsmtf_pkg::clamp_dim(geom.source_width, hsmtf_pkg::MAX_WIDTH);
        h_e  = hsmtf_pkg::clamp_dim(geom.source_height, hsmtf_pkg::MAX_HEIGHT);
        n_e  = hsmtf_pkg::clamp_frame(geom.frame_size);
        hw_e = (w_e + SW'(1)) >> 1;
        hh_e = (h_e + SW'(1)) >> 1;
        ow   = w_e + (n_e << 1) + n_e;
        oh   = h_e + (n_e << 1) + n_e;
        up   = (h_e >> 1) + (n_e << 1);
        rend = w_e - SW'(1) + (n_e << 1);
        rs   = w_e - hw_e + (n_e << 1);
        r_e  = SW'(emit_row_reg);
        c_e  = SW'(emit_col_reg);
        lr_e = SW'(load_row_reg);
        lc_e = SW'(load_col_reg);

        row_ok = 1'b1;
        i_e    = '0;
        if (r_e >= n_e && r_e < n_e + hh_e) begin
            i_e = hh_e - SW'(1) + n_e - r_e;
        end else if (r_e >= up && r_e < up + hh_e) begin
            i_e = r_e - up;
        end else begin
            row_ok = 1'b0;
        end

        col_ok = 1'b1;
        j_e    = '0;
        if (c_e >= n_e && c_e < n_e + hw_e) begin
            j_e = c_e - n_e;
        end else if (c_e >= rs && c_e <= rend) begin
            j_e = rend - c_e;
        end else begin
            col_ok = 1'b0;
        end

        em_i    = i_e[hsmtf_pkg::HROW_W-1:0];
        em_j    = j_e[hsmtf_pkg::HCOL_W-1:0];
        em_addr = hsmtf_pkg::ADDR_W'(em_i) * hsmtf_pkg::ADDR_W'(hsmtf_pkg::HALF_W)
                  + hsmtf_pkg::ADDR_W'(em_j);

        row_end   = (c_e + SW'(1)) >= ow;
        image_end = row_end && ((r_e + SW'(1)) >= oh);

        load_ok = (lr_e < h_e) && (lc_e < w_e) && !load_row_reg[0] && !load_col_reg[0];
        ld_i    = hsmtf_pkg::HROW_W'(load_row_reg >> 1);
        ld_j    = hsmtf_pkg::HCOL_W'(load_col_reg >> 1);
        ld_addr = hsmtf_pkg::ADDR_W'(ld_i) * hsmtf_pkg::ADDR_W'(hsmtf_pkg::HALF_W)
                  + hsmtf_pkg::ADDR_W'(ld_j);

        do_load  = accept && (operation == hsmtf_pkg::OP_LOAD);
        do_fetch = accept && (operation == hsmtf_pkg::OP_FETCH);

        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        if (do_load) begin
            if ((lc_e + SW'(1)) >= w_e) begin
                load_col_next = '0;
                if ((lr_e + SW'(1)) >= h_e) begin
                    load_row_next = '0;
                end else begin
                    load_row_next = load_row_reg + 1'b1;
                end
            end else begin
                load_col_next = load_col_reg + 1'b1;
            end
        end

        emit_row_next = emit_row_reg;
        emit_col_next = emit_col_reg;
        if (do_fetch) begin
            if (row_end) begin
                emit_col_next = '0;
                emit_row_next = image_end ? '0 : emit_row_reg + 1'b1;
            end else begin
                emit_col_next = emit_col_reg + 1'b1;
            end
        end

        ctrl.we        = do_load && load_ok;
        ctrl.re        = do_fetch;
        ctrl.addr      = do_load ? ld_addr : em_addr;
        ctrl.use_store = row_ok && col_ok;
        ctrl.row_end   = row_end;
        ctrl.image_end = image_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_row_reg <= '0;
            load_col_reg <= '0;
            emit_row_reg <= '0;
            emit_col_reg <= '0;
        end else begin
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
            emit_row_reg <= emit_row_next;
            emit_col_reg <= emit_col_next;
        end
    end

endmodule

// ----- rtl/half_scale_mirror_tile_framer_core.sv -----
// Top level: configuration registers, half image store and the fetch result pipeline.
// A fetch request gives a result and a load gives none.
// One request of either kind is accepted per cycle while the result side keeps up.
// The fetch path runs through the store read register and then the result register.
// Reset clears the positions and sets the registers to their defaults.
// The half image store is not cleared and holds earlier images until overwritten.
module half_scale_mirror_tile_framer_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [hsmtf_pkg::PIXEL_W-1:0]      s_tdata,   // in_blue, in_green, in_red
    input  logic                               s_tuser,   // operation
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hsmtf_pkg::PIXEL_W-1:0]      m_tdata,   // out_blue, out_green, out_red
    output logic                               m_tlast,
    output logic                               m_tuser,   // image_end
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hsmtf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hsmtf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW = hsmtf_pkg::COLOR_W;

    logic [hsmtf_pkg::DIM_REG_W-1:0]   width_reg, height_reg;
    logic [hsmtf_pkg::FRAME_REG_W-1:0] fsize_reg;
    logic [CW-1:0]                     red_reg, green_reg, blue_reg;

    hsmtf_pkg::geom_t geom;
    hsmtf_pkg::ctrl_t ctrl;

    logic                          s_fire;
    logic                          out_room;
    logic                          s1_valid_reg, s1_use_store_reg, s1_row_end_reg;
    logic                          s1_image_end_reg;
    logic [hsmtf_pkg::PIXEL_W-1:0] s1_frame_reg;
    logic [hsmtf_pkg::PIXEL_W-1:0] store_rdata;
    logic                          m_valid_reg, m_last_reg, m_user_reg;
    logic [hsmtf_pkg::PIXEL_W-1:0] m_data_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= hsmtf_pkg::DIM_REG_W'(hsmtf_pkg::MAX_WIDTH);
            height_reg <= hsmtf_pkg::DIM_REG_W'(hsmtf_pkg::MAX_HEIGHT);
            fsize_reg  <= hsmtf_pkg::FRAME_REG_W'(hsmtf_pkg::FRAME_MIN);
            red_reg    <= '0;
            green_reg  <= '0;
            blue_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                hsmtf_pkg::CFG_SOURCE_WIDTH:  width_reg  <= cfg_data;
                hsmtf_pkg::CFG_SOURCE_HEIGHT: height_reg <= cfg_data;
                hsmtf_pkg::CFG_FRAME_SIZE:    fsize_reg  <= cfg_data[hsmtf_pkg::FRAME_REG_W-1:0];
                hsmtf_pkg::CFG_FRAME_RED:     red_reg    <= cfg_data[CW-1:0];
                hsmtf_pkg::CFG_FRAME_GREEN:   green_reg  <= cfg_data[CW-1:0];
                hsmtf_pkg::CFG_FRAME_BLUE:    blue_reg   <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    assign geom.source_width  = width_reg;
    assign geom.source_height = height_reg;
    assign geom.frame_size    = fsize_reg;

    assign out_room = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_room;
    assign s_fire   = s_tvalid && s_tready;

    hsmtf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_fire),
        .operation (s_tuser),
        .geom      (geom),
        .ctrl      (ctrl)
    );

    hsmtf_ram #(
        .WIDTH (hsmtf_pkg::PIXEL_W),
        .DEPTH (hsmtf_pkg::STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ctrl.we),
        .waddr (ctrl.addr),
        .wdata (s_tdata),
        .re    (ctrl.re),
        .raddr (ctrl.addr),
        .rdata (store_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= ctrl.re;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.re) begin
            s1_use_store_reg <= ctrl.use_store;
            s1_row_end_reg   <= ctrl.row_end;
            s1_image_end_reg <= ctrl.image_end;
            s1_frame_reg     <= {red_reg, green_reg, blue_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_room) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_room && s1_valid_reg) begin
            m_data_reg <= s1_use_store_reg ? store_rdata : s1_frame_reg;
            m_last_reg <= s1_row_end_reg;
            m_user_reg <= s1_image_end_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

    a_image_end_ends_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("image end without row end");

    a_store_read_on_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.re |-> s_fire && (s_tuser == hsmtf_pkg::OP_FETCH))
        else $error("store read without accepted fetch");

    a_no_read_write_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl.we && ctrl.re))
        else $error("store written and read in one cycle");

    a_stalled_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !out_room |-> !ctrl.re ##1 s1_valid_reg)
        else $error("pipeline stage lost while stalled");

endmodule

// ----- tb/tb_half_scale_mirror_tile_framer_core.sv -----
// Self-checking testbench for the half scale mirror tile framer core.
`timescale 1ns / 100ps

module tb_half_scale_mirror_tile_framer_core;

    localparam int MAX_WIDTH   = hsmtf_pkg::MAX_WIDTH;
    localparam int MAX_HEIGHT  = hsmtf_pkg::MAX_HEIGHT;
    localparam int FRAME_MIN   = hsmtf_pkg::FRAME_MIN;
    localparam int FRAME_MAX   = hsmtf_pkg::FRAME_MAX;
    localparam int HALF_W      = hsmtf_pkg::HALF_W;
    localparam int STORE_DEPTH = hsmtf_pkg::STORE_DEPTH;
    localparam int DIM_REG_W   = hsmtf_pkg::DIM_REG_W;
    localparam int FRAME_REG_W = hsmtf_pkg::FRAME_REG_W;
    localparam int COLOR_W     = hsmtf_pkg::COLOR_W;
    localparam int PIXEL_W     = hsmtf_pkg::PIXEL_W;
    localparam int CFG_INDEX_W = hsmtf_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = hsmtf_pkg::CFG_DATA_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = hsmtf_pkg::CFG_SOURCE_WIDTH;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = hsmtf_pkg::CFG_SOURCE_HEIGHT;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_SIZE    = hsmtf_pkg::CFG_FRAME_SIZE;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_RED     = hsmtf_pkg::CFG_FRAME_RED;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_GREEN   = hsmtf_pkg::CFG_FRAME_GREEN;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BLUE    = hsmtf_pkg::CFG_FRAME_BLUE;

    localparam logic OP_LOAD  = hsmtf_pkg::OP_LOAD;
    localparam logic OP_FETCH = hsmtf_pkg::OP_FETCH;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 20;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               row_end;
        logic               image_end;
    } out_pixel_t;

    typedef struct packed {
        logic [DIM_REG_W-1:0]   width;
        logic [DIM_REG_W-1:0]   height;
        logic [FRAME_REG_W-1:0] border;
        logic [COLOR_W-1:0]     red;
        logic [COLOR_W-1:0]     green;
        logic [COLOR_W-1:0]     blue;
    } frame_setup_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [PIXEL_W-1:0]     s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [PIXEL_W-1:0]     m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic [PIXEL_W-1:0]     half_store [STORE_DEPTH];
    bit                     half_written [STORE_DEPTH];
    int unsigned            load_x;
    int unsigned            load_y;
    int unsigned            emit_x;
    int unsigned            emit_y;
    logic [DIM_REG_W-1:0]   width_reg;
    logic [DIM_REG_W-1:0]   height_reg;
    logic [FRAME_REG_W-1:0] border_reg;
    logic [COLOR_W-1:0]     red_reg;
    logic [COLOR_W-1:0]     green_reg;
    logic [COLOR_W-1:0]     blue_reg;

    out_pixel_t             expected_pixels [$];
    int                     mismatch_count = 0;
    int                     idle_cycles = 0;
    int                     send_gap_pct = 0;
    int                     ready_stall_pct = 0;

    half_scale_mirror_tile_framer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end

    function automatic int unsigned used_width();
        if (width_reg == '0) return 1;
        return (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    endfunction

    function automatic int unsigned used_height();
        if (height_reg == '0) return 1;
        return (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
    endfunction

    function automatic int unsigned used_border();
        if (border_reg < FRAME_MIN) return FRAME_MIN;
        return (border_reg > FRAME_MAX) ? FRAME_MAX : border_reg;
    endfunction

    function automatic void reset_predictor();
        for (int k = 0; k < STORE_DEPTH; k++) begin
            half_written[k] = 1'b0;
        end
        load_x = 0;
        load_y = 0;
        emit_x = 0;
        emit_y = 0;
        width_reg = DIM_REG_W'(MAX_WIDTH);
        height_reg = DIM_REG_W'(MAX_HEIGHT);
        border_reg = FRAME_REG_W'(FRAME_MIN);
        red_reg = '0;
        green_reg = '0;
        blue_reg = '0;
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] index,
                                           input logic [CFG_DATA_W-1:0] value);
        case (index)
            CFG_SOURCE_WIDTH:  width_reg = value[DIM_REG_W-1:0];
            CFG_SOURCE_HEIGHT: height_reg = value[DIM_REG_W-1:0];
            CFG_FRAME_SIZE:    border_reg = value[FRAME_REG_W-1:0];
            CFG_FRAME_RED:     red_reg = value[COLOR_W-1:0];
            CFG_FRAME_GREEN:   green_reg = value[COLOR_W-1:0];
            CFG_FRAME_BLUE:    blue_reg = value[COLOR_W-1:0];
            default: ;
        endcase
    endfunction

    // Store entry shown at the current output position, or -1 where the frame colour shows.
    function automatic int mirror_slot();
        int unsigned w;
        int unsigned hw;
        int unsigned hh;
        int unsigned n;
        int unsigned upper_top;
        int unsigned right_end;
        int unsigned right_start;
        int unsigned i;
        int unsigned j;
        w = used_width();
        n = used_border();
        hw = (w + 1) / 2;
        hh = (used_height() + 1) / 2;
        upper_top = used_height() / 2 + 2 * n;
        right_end = w - 1 + 2 * n;
        right_start = w - hw + 2 * n;
        if (emit_y >= n && emit_y < n + hh) begin
            i = hh - 1 - (emit_y - n);
        end else if (emit_y >= upper_top && emit_y < upper_top + hh) begin
            i = emit_y - upper_top;
        end else begin
            return -1;
        end
        if (emit_x >= n && emit_x < n + hw) begin
            j = emit_x - n;
        end else if (emit_x >= right_start && emit_x <= right_end) begin
            j = right_end - emit_x;
        end else begin
            return -1;
        end
        return i * HALF_W + j;
    endfunction

    function automatic bit fetch_is_safe();
        int slot;
        slot = mirror_slot();
        return (slot < 0) || half_written[slot];
    endfunction

    function automatic void capture_source_pixel(input logic [PIXEL_W-1:0] pixel);
        int unsigned w;
        int unsigned h;
        int unsigned slot;
        w = used_width();
        h = used_height();
        if (load_y < h && load_x < w && load_y % 2 == 0 && load_x % 2 == 0) begin
            slot = (load_y / 2) * HALF_W + load_x / 2;
            half_store[slot] = pixel;
            half_written[slot] = 1'b1;
        end
        if (load_x + 1 >= w) begin
            load_x = 0;
            load_y = (load_y + 1 >= h) ? 0 : load_y + 1;
        end else begin
            load_x++;
        end
    endfunction

    function automatic void compose_output_pixel();
        int unsigned out_w;
        int unsigned out_h;
        int slot;
        logic [PIXEL_W-1:0] pixel;
        out_pixel_t res;
        out_w = used_width() + 3 * used_border();
        out_h = used_height() + 3 * used_border();
        slot = mirror_slot();
        pixel = (slot < 0) ? {red_reg, green_reg, blue_reg} : half_store[slot];
        res.red = pixel[2*COLOR_W +: COLOR_W];
        res.green = pixel[COLOR_W +: COLOR_W];
        res.blue = pixel[0 +: COLOR_W];
        res.row_end = (emit_x + 1 >= out_w);
        res.image_end = res.row_end && (emit_y + 1 >= out_h);
        expected_pixels.push_back(res);
        if (res.row_end) begin
            emit_x = 0;
            emit_y = res.image_end ? 0 : emit_y + 1;
        end else begin
            emit_x++;
        end
    endfunction

    function automatic frame_setup_t make_setup(input int w, input int h, input int n,
                                                input int r, input int g, input int b);
        frame_setup_t s;
        s.width = DIM_REG_W'(w);
        s.height = DIM_REG_W'(h);
        s.border = FRAME_REG_W'(n);
        s.red = COLOR_W'(r);
        s.green = COLOR_W'(g);
        s.blue = COLOR_W'(b);
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
        end
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode % 4)
            0: begin
                send_gap_pct = 0;
                ready_stall_pct = 0;
            end
            1: begin
                send_gap_pct = 48;
                ready_stall_pct = 0;
            end
            2: begin
                send_gap_pct = 0;
                ready_stall_pct = 48;
            end
            default: begin
                send_gap_pct = 22;
                ready_stall_pct = 22;
            end
        endcase
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (expected_pixels.size() != 0) @(negedge aclk);
    endtask

    task automatic program_setup(input frame_setup_t s);
        logic [CFG_INDEX_W-1:0] index [6];
        logic [CFG_DATA_W-1:0]  value [6];
        index = '{CFG_SOURCE_WIDTH, CFG_SOURCE_HEIGHT, CFG_FRAME_SIZE,
                  CFG_FRAME_RED, CFG_FRAME_GREEN, CFG_FRAME_BLUE};
        value = '{CFG_DATA_W'(s.width), CFG_DATA_W'(s.height), CFG_DATA_W'(s.border),
                  CFG_DATA_W'(s.red), CFG_DATA_W'(s.green), CFG_DATA_W'(s.blue)};
        for (int k = 0; k < 6; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= index[k];
            cfg_data <= value[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            apply_register(index[k], value[k]);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Registers change only once the block has gone quiet, loads included.
    task automatic start_phase(input frame_setup_t s, input int mode);
        drain_results();
        repeat (4) @(negedge aclk);
        set_idle_mode(mode);
        program_setup(s);
    endtask

    task automatic send_request(input logic op, input logic [PIXEL_W-1:0] pixel);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= pixel;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op == OP_FETCH) begin
            compose_output_pixel();
        end else begin
            capture_source_pixel(pixel);
        end
        @(negedge aclk);
    endtask

    // A fetch that would show a never loaded store entry is turned into a load.
    task automatic stream_pixels(input int count, input int fetch_pct, input int pause_at);
        logic op;
        for (int k = 0; k < count; k++) begin
            if (k == pause_at) drain_results();
            op = ($urandom_range(99) < fetch_pct) ? OP_FETCH : OP_LOAD;
            if (op == OP_FETCH && !fetch_is_safe()) op = OP_LOAD;
            send_request(op, PIXEL_W'($urandom));
        end
    endtask

    task automatic test_directed_extremes();
        logic [PIXEL_W-1:0] sources [5];
        sources = '{24'hFFFFFF, 24'h000000, 24'h00FF00, 24'hFF00FF, 24'h123456};
        start_phase(make_setup(2, 2, 0, 255, 0, 255), 0);
        foreach (sources[k]) begin
            send_request(OP_LOAD, sources[k]);
        end
        for (int k = 0; k < 16; k++) begin
            send_request(OP_FETCH, (k % 2 == 0) ? 24'hFFFFFF : 24'h000000);
        end
    endtask

    task automatic test_small_frames();
        start_phase(make_setup(1, 1, 4, 0, 255, 0), 1);
        stream_pixels(250, 75, -1);
        start_phase(make_setup(2, 3, 5, 255, 255, 0), 2);
        stream_pixels(150, 80, -1);
        start_phase(make_setup(4, 2, 4, 0, 0, 255), 3);
        stream_pixels(100, 80, -1);
    endtask

    task automatic test_random_frames();
        frame_setup_t s;
        int n;
        for (int k = 0; k < 6; k++) begin
            n = $urandom_range(1) ? $urandom_range(0, 31) : $urandom_range(4, 7);
            s = make_setup($urandom_range(0, 10), $urandom_range(0, 10), n,
                           $urandom_range(255), $urandom_range(255), $urandom_range(255));
            start_phase(s, k);
            stream_pixels(90, 70, 45);
        end
    endtask

    task automatic test_wide_frame();
        start_phase(make_setup(511, 2, 4, 0, 0, 0), 2);
        stream_pixels(300, 55, -1);
    endtask

    task automatic test_tall_frame();
        start_phase(make_setup(0, 256, 4, 255, 255, 255), 1);
        stream_pixels(200, 65, -1);
    endtask

    task automatic test_deep_border();
        start_phase(make_setup(1, 1, 31, 128, 64, 32), 3);
        stream_pixels(200, 97, -1);
    endtask

    always @(posedge aclk) begin : result_check
        out_pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 0);
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata[0 +: COLOR_W] !== want.blue)
                    report_mismatch("out_blue", m_tdata[0 +: COLOR_W], want.blue);
                if (m_tdata[COLOR_W +: COLOR_W] !== want.green)
                    report_mismatch("out_green", m_tdata[COLOR_W +: COLOR_W], want.green);
                if (m_tdata[2*COLOR_W +: COLOR_W] !== want.red)
                    report_mismatch("out_red", m_tdata[2*COLOR_W +: COLOR_W], want.red);
                if (m_tlast !== want.row_end)
                    report_mismatch("row_end", m_tlast, want.row_end);
                if (m_tuser !== want.image_end)
                    report_mismatch("image_end", m_tuser, want.image_end);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_LOAD;
        cfg_valid = 1'b0;
        cfg_index = CFG_SOURCE_WIDTH;
        cfg_data = '0;
        aresetn = 1'b0;
        reset_predictor();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_extremes();
        test_small_frames();
        test_random_frames();
        test_wide_frame();
        test_tall_frame();
        test_deep_border();
        drain_results();
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/hsmtf_pkg.sv
rtl/hsmtf_ram.sv
rtl/hsmtf_ctrl.sv
rtl/half_scale_mirror_tile_framer_core.sv
tb/tb_half_scale_mirror_tile_framer_core.sv
